@@ rtl/ssnfw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssnfw_pkg
// Shared types, constants and glyph table for the seven segment frame writer.
// ----------------------------------------------------------------------------
package ssnfw_pkg;

	localparam int VALUE_W     = 21;
	localparam int MAG_W       = 20;
	localparam int BCD_DIGITS  = 6;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int DD_STAGES   = 4;
	localparam int DD_STEPS    = MAG_W / DD_STAGES;
	localparam int NUM_FRAMES  = 6;
	localparam int FRAME_CNT_W = 3;
	localparam int NDIG_W      = 3;
	localparam int PADDR_W     = 3;

	localparam logic signed [VALUE_W-1:0] CLIP_HIGH = 21'sd999999;
	localparam logic signed [VALUE_W-1:0] CLIP_LOW  = -21'sd99999;

	localparam logic [6:0] MINUS_GLYPH = 7'h02;
	localparam logic [6:0] BLANK_GLYPH = 7'h00;
	localparam logic [2:0] FRAME_ID    = 3'b101;

	localparam logic [FRAME_CNT_W-1:0] LAST_FRAME = 3'd5;
	localparam logic [5:0]             LAST_ADDR  = 6'd10;

	// register index, taken from paddr[2]
	localparam logic REG_BATTERY = 1'b0;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [1:0]                decimals;
		logic                      zero_pad;
	} number_t;

	typedef struct packed {
		logic [5:0]  address;
		logic [7:0]  segments;
		logic [16:0] frame_word;
		logic        last;
	} frame_t;

	// payload through the binary to BCD converter
	typedef struct packed {
		logic             neg;
		logic [1:0]       dec;
		logic             pad;
		logic             tiny;
		logic [MAG_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} dd_t;

	typedef logic [NUM_FRAMES-1:0][7:0] seg_row_t;

	typedef struct packed {
		logic s6;
		logic s7;
	} fmt_en_t;

	function automatic logic [6:0] digit_glyph(input logic [3:0] d);
		logic [6:0] g;
		case (d)
			4'd0: g = 7'h7D;
			4'd1: g = 7'h60;
			4'd2: g = 7'h3E;
			4'd3: g = 7'h7A;
			4'd4: g = 7'h63;
			4'd5: g = 7'h5B;
			4'd6: g = 7'h5F;
			4'd7: g = 7'h70;
			4'd8: g = 7'h7F;
			4'd9: g = 7'h7B;
			default: g = BLANK_GLYPH;
		endcase
		return g;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pow_ten(input logic [1:0] d);
		logic signed [VALUE_W-1:0] p;
		case (d)
			2'd0: p = 21'sd1;
			2'd1: p = 21'sd10;
			2'd2: p = 21'sd100;
			2'd3: p = 21'sd1000;
			default: p = 21'sd1;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ssnfw_bcd_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssnfw_bcd_stage
// One register stage of the shift-and-add-3 binary to BCD converter.
// ----------------------------------------------------------------------------
module ssnfw_bcd_stage
	import ssnfw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire dd_t  dd_in,
	output logic      valid_out,
	output dd_t       dd_out
);

	logic valid_sn;
	dd_t  dd_sn;
	dd_t  dd_next;

	always_comb begin
		logic [BCD_W-1:0] b;
		logic [MAG_W-1:0] m;
		b = dd_in.bcd;
		m = dd_in.bin;
		for (int s = 0; s < DD_STEPS; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5) begin
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
				end
			end
			{b, m} = {b[BCD_W-2:0], m, 1'b0};
		end
		dd_next     = dd_in;
		dd_next.bcd = b;
		dd_next.bin = m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			dd_sn <= dd_next;
		end
	end

	assign valid_out = valid_sn;
	assign dd_out    = dd_sn;

endmodule
`default_nettype wire

@@ rtl/ssnfw_format.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssnfw_format
// Digit count and padding (s6), then glyphs, minus sign and bit 7 (s7).
// ----------------------------------------------------------------------------
module ssnfw_format
	import ssnfw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire fmt_en_t    en,
	input  wire logic       valid_in,
	input  wire dd_t        dd_in,
	input  wire logic [1:0] battery_level,
	output logic            valid_s6,
	output logic            valid_s7,
	output seg_row_t        segs_s7
);

	typedef struct packed {
		logic              neg;
		logic [1:0]        dec;
		logic [NDIG_W-1:0] ndig;
		logic [BCD_W-1:0]  bcd;
	} fmt_t;

	fmt_t     fmt_next;
	fmt_t     fmt_s6;
	seg_row_t segs_next;

	// digits shown = highest nonzero digit, at least one, widened by padding
	always_comb begin
		int h;
		int w;
		h = 1;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (dd_in.bcd[4*i +: 4] != 4'd0) begin
				h = i + 1;
			end
		end
		if (dd_in.tiny) begin
			w = int'(dd_in.dec) + 1;
		end else if (dd_in.neg) begin
			w = BCD_DIGITS - 1;
		end else begin
			w = BCD_DIGITS;
		end
		if (dd_in.pad && h < w) begin
			h = w;
		end
		fmt_next.neg  = dd_in.neg;
		fmt_next.dec  = dd_in.dec;
		fmt_next.ndig = NDIG_W'(h);
		fmt_next.bcd  = dd_in.bcd;
	end

	// byte p shows digit 5-p; byte 5 is the ones digit
	always_comb begin
		int i;
		for (int p = 0; p < NUM_FRAMES; p++) begin
			i = NUM_FRAMES - 1 - p;
			if (i < int'(fmt_s6.ndig)) begin
				segs_next[p][6:0] = digit_glyph(fmt_s6.bcd[4*i +: 4]);
			end else if (fmt_s6.neg && i == int'(fmt_s6.ndig)) begin
				segs_next[p][6:0] = MINUS_GLYPH;
			end else begin
				segs_next[p][6:0] = BLANK_GLYPH;
			end
			segs_next[p][7] = (p < 3 && int'(battery_level) > 2 - p) ||
				(fmt_s6.dec != 2'd0 && p == NUM_FRAMES - int'(fmt_s6.dec));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en.s6) begin
				valid_s6 <= valid_in;
			end
			if (en.s7) begin
				valid_s7 <= valid_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6 && valid_in) begin
			fmt_s6 <= fmt_next;
		end
		if (en.s7 && valid_s6) begin
			segs_s7 <= segs_next;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ssnfw_emitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssnfw_emitter
// Holds one number's six segment bytes and sends one frame beat per cycle.
// ----------------------------------------------------------------------------
module ssnfw_emitter
	import ssnfw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire seg_row_t segs,
	output logic          ready,
	output logic          frame_valid,
	output frame_t        frame
);

	logic                   active_q;
	logic [FRAME_CNT_W-1:0] cnt_q;
	logic [7:0]             seg_buf_q [NUM_FRAMES];
	logic                   frame_valid_q;
	frame_t                 frame_q;
	logic [5:0]             addr;
	logic [7:0]             data;

	// a new number may load while the last frame of the current one goes out
	assign ready = !active_q || cnt_q == LAST_FRAME;

	assign addr = {2'b00, cnt_q, 1'b0};
	assign data = seg_buf_q[cnt_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			cnt_q         <= '0;
			frame_valid_q <= 1'b0;
		end else begin
			frame_valid_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (cnt_q == LAST_FRAME) begin
					active_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// buffer is stored in send order: highest byte first
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_FRAMES; k++) begin
				seg_buf_q[k] <= segs[NUM_FRAMES - 1 - k];
			end
		end
		if (active_q) begin
			frame_q.address    <= addr;
			frame_q.segments   <= data;
			frame_q.frame_word <= {FRAME_ID, addr, data};
			frame_q.last       <= cnt_q == LAST_FRAME;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

endmodule
`default_nettype wire

@@ rtl/seven_segment_number_frame_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_frame_writer
// Clips a scaled number, converts it to six display characters and writes
// them out as six serial write frames, one beat per cycle.
// ----------------------------------------------------------------------------
// A number passes s1, s2..s5, s6 and s7, then the emitter loads it and strobes
// its six frame beats back to back; the receiver cannot stall them.
// Throughput: the emitter sends one frame per cycle and loads the next number
// on the last beat of the current one; the seven-stage pipeline ahead of it
// takes a number per cycle until it fills, then busy rises.
// Reset: pipeline and emitter empty, busy low, battery_level 0.
// ----------------------------------------------------------------------------
module seven_segment_number_frame_writer
	import ssnfw_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// number command
	input  wire logic               start,
	output logic                    busy,
	input  wire number_t            number,
	// frame beats
	output logic                    frame_valid,
	output frame_t                  frame,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// ---------------- register port ----------------
	logic [1:0] battery_q;
	logic       reg_sel;

	// register index is the word address
	assign reg_sel = paddr[PADDR_W-1] == REG_BATTERY;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {30'd0, battery_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_q <= 2'd0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			battery_q <= pwdata[1:0];
		end
	end

	// ---------------- stall chain ----------------
	// Each stage loads when it is empty or its contents move on. The chain
	// ends at the emitter, which frees up on the last beat of a number.
	logic    valid_s1;
	logic    en_s1;
	logic    accept;
	logic    valid_s6;
	logic    valid_s7;
	logic    emit_ready;
	logic    emit_load;
	fmt_en_t fmt_en;

	logic valid_bus [DD_STAGES+1];
	dd_t  dd_bus    [DD_STAGES+1];
	logic en_bus    [DD_STAGES+1];

	assign fmt_en.s7 = !valid_s7 || emit_ready;
	assign fmt_en.s6 = !valid_s6 || fmt_en.s7;
	assign emit_load = valid_s7 && emit_ready;

	assign en_s1  = !valid_s1 || en_bus[1];
	assign busy   = !en_s1;
	assign accept = start && !busy;

	// ---------------- s1: clip, sign, magnitude ----------------
	logic signed [VALUE_W-1:0] clipped;
	logic signed [VALUE_W-1:0] negated;
	logic signed [VALUE_W-1:0] limit;
	logic                      tiny;
	dd_t                       dd_next;
	dd_t                       dd_s1;

	always_comb begin
		if (number.value > CLIP_HIGH) begin
			clipped = CLIP_HIGH;
		end else if (number.value < CLIP_LOW) begin
			clipped = CLIP_LOW;
		end else begin
			clipped = number.value;
		end
	end

	assign negated = -clipped;

	// tiny needs |value| < 10^dec <= 1000, where clipping never applies,
	// so it is checked on the raw value alongside the clip
	assign limit = pow_ten(number.decimals);
	assign tiny  = number.decimals != 2'd0 && number.value < limit && number.value > -limit;

	always_comb begin
		dd_next.neg  = clipped[VALUE_W-1];
		dd_next.dec  = number.decimals;
		dd_next.pad  = number.zero_pad;
		dd_next.tiny = tiny;
		dd_next.bin  = clipped[VALUE_W-1] ? negated[MAG_W-1:0] : clipped[MAG_W-1:0];
		dd_next.bcd  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dd_s1 <= dd_next;
		end
	end

	// ---------------- s2..s5: binary to BCD ----------------
	assign valid_bus[0] = valid_s1;
	assign dd_bus[0]    = dd_s1;
	assign en_bus[0]    = en_s1;

	for (genvar k = 1; k <= DD_STAGES; k++) begin : g_dd
		if (k == DD_STAGES) begin : g_tail
			assign en_bus[k] = !valid_bus[k] || fmt_en.s6;
		end else begin : g_mid
			assign en_bus[k] = !valid_bus[k] || en_bus[k+1];
		end

		ssnfw_bcd_stage u_bcd (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en_bus[k]),
			.valid_in  (valid_bus[k-1]),
			.dd_in     (dd_bus[k-1]),
			.valid_out (valid_bus[k]),
			.dd_out    (dd_bus[k])
		);
	end

	// ---------------- s6..s7: characters to segment bytes ----------------
	seg_row_t segs_s7;

	ssnfw_format u_format (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (fmt_en),
		.valid_in      (valid_bus[DD_STAGES]),
		.dd_in         (dd_bus[DD_STAGES]),
		.battery_level (battery_q),
		.valid_s6      (valid_s6),
		.valid_s7      (valid_s7),
		.segs_s7       (segs_s7)
	);

	// ---------------- frame emitter ----------------
	ssnfw_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (emit_load),
		.segs        (segs_s7),
		.ready       (emit_ready),
		.frame_valid (frame_valid),
		.frame       (frame)
	);

	// ---------------- checks ----------------
	// busy only ever comes from a held first stage
	a_busy_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1)
		else $error("busy raised with empty first stage");

	// the six beats of one number are back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame.last |=> frame_valid)
		else $error("gap inside a number's frames");

	// a beat other than the first continues the previous one
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame.address != 6'd0 |->
			$past(frame_valid) && $past(frame.address) + 6'd2 == frame.address)
		else $error("frame address out of sequence");

	// last marks the top address
	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame.last == (frame.address == LAST_ADDR))
		else $error("last flag does not match address");

endmodule
`default_nettype wire
